### rtl/kof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kof_pkg: shared types and constants of the key offset frequency filter
// Holds the request types of both channels, the queue record and the
// state type of the back end.
// ----------------------------------------------------------------------------
package kof_pkg;

    // Offset counts saturate at this value.
    localparam logic [6:0] CNT_MAX = 7'd127;

    // Reset value of the match limit register.
    localparam logic [6:0] MAX_MATCHES_RST = 7'd8;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One input request.
    typedef struct packed {
        logic [7:0]  key_offset;
        logic [15:0] contig;
        logic [31:0] position;
        logic        strand;
        logic        last_entry;
    } t_kof_in;

    // One result request.
    typedef struct packed {
        logic [15:0] kept_contig;
        logic [31:0] kept_position;
        logic        kept_strand;
        logic        set_empty;
        logic        overflowed;
        logic        last_result;
    } t_kof_out;

    // Classified entry handed from front to back.
    typedef struct packed {
        t_kof_in entry;
        logic    drop;
    } t_kof_rec;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_UPD,
        B_SRD,
        B_CRD,
        B_CHK,
        B_FIN,
        B_CLR_RD,
        B_CLR_WR
    } t_kof_bstate;

endpackage

### rtl/kof_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kof_front: input acceptance and classification
// Accepts entries, tracks how many of the current set fit in the store and
// marks the ones beyond its capacity as dropped before queueing them.
// ----------------------------------------------------------------------------
module kof_front #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  kof_pkg::t_kof_in i_in_data,
    output logic             o_in_stall,
    input  logic             i_queue_full,
    input  logic             i_init_busy,
    output logic             o_push,
    output kof_pkg::t_kof_rec o_rec
);
    import kof_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic          store_full;

    // No request is taken while the queue is full or the count memory is cleared after reset.
    assign o_in_stall = i_queue_full | i_init_busy;
    assign o_push     = i_in_valid & ~o_in_stall;
    assign store_full = (r_fill == CW'(MAX_ENTRIES));

    assign o_rec.entry = i_in_data;
    assign o_rec.drop  = store_full;

    // Fill count of the current set; it restarts after the last entry.
    always_comb begin
        n_fill = r_fill;
        if (o_push) begin
            if (i_in_data.last_entry) begin
                n_fill = '0;
            end else if (!store_full) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

### rtl/kof_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kof_queue: short record queue between front and back
// A small first-in first-out buffer so that each side can stall on its own.
// ----------------------------------------------------------------------------
module kof_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kof_pkg::t_kof_rec i_rec,
    output logic              o_full,
    output logic              o_valid,
    output kof_pkg::t_kof_rec o_rec,
    input  logic              i_pop
);
    import kof_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);

    t_kof_rec         r_buf [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr;
    logic [QPW-1:0]   r_rd;
    logic [QPW:0]     r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (QPW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_buf[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_rec;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/kof_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kof_back: counting, storing and filtered emission
// Owns the offset count memory and the entry store. Counts and stores each
// queued entry that is not dropped, and after the last one of a set walks
// the store to emit the kept entries, then again to clear the counts it used.
// ----------------------------------------------------------------------------
module kof_back #(
    parameter int KEY_OFFSETS = 256,
    parameter int MAX_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_max_matches,
    input  logic              i_rec_valid,
    input  kof_pkg::t_kof_rec i_rec,
    output logic              o_rec_pop,
    output logic              o_init_busy,
    output logic              o_out_valid,
    output kof_pkg::t_kof_out o_out_data,
    input  logic              i_out_stall
);
    import kof_pkg::*;

    localparam int IW = $clog2(KEY_OFFSETS);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Key offset to count index: the offset taken modulo the table size.
    function automatic logic [256*IW-1:0] build_idx_tab();
        logic [256*IW-1:0] tab;
        int                r;
        tab = '0;
        r   = 0;
        for (int i = 0; i < 256; i++) begin
            tab[i*IW +: IW] = IW'(r);
            r = r + 1;
            if (r == KEY_OFFSETS) begin
                r = 0;
            end
        end
        return tab;
    endfunction

    localparam logic [256*IW-1:0] IDX_TAB = build_idx_tab();

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [15:0]   contig;
        logic [31:0]   position;
        logic          strand;
    } t_slot;

    // Memories and their read registers.
    logic [6:0]    r_cnt_mem [KEY_OFFSETS];
    logic [6:0]    r_cnt_q;
    t_slot         r_st_mem [MAX_ENTRIES];
    t_slot         r_st_q;

    // Memory port controls.
    logic          cnt_re;
    logic [IW-1:0] cnt_ra;
    logic          cnt_we;
    logic [IW-1:0] cnt_wa;
    logic [6:0]    cnt_wd;
    logic          st_re;
    logic [AW-1:0] st_ra;
    logic          st_we;
    logic [AW-1:0] st_wa;
    t_slot         st_wd;

    // Sequencer and payload registers.
    t_kof_bstate   r_state;
    t_kof_bstate   n_state;
    t_kof_rec      r_rec;
    t_kof_rec      n_rec;
    t_slot         r_ent;
    t_slot         n_ent;
    t_slot         r_pend;
    t_slot         n_pend;
    logic          r_pend_v;
    logic          n_pend_v;
    logic [CW-1:0] r_wptr;
    logic [CW-1:0] n_wptr;
    logic          r_ovf;
    logic          n_ovf;
    logic [CW-1:0] r_scan;
    logic [CW-1:0] n_scan;
    logic [CW-1:0] scan_inc;
    logic [IW-1:0] r_init;
    logic [IW-1:0] n_init;
    t_kof_out      r_out;
    t_kof_out      n_out;
    logic          r_out_v;
    logic          n_out_v;

    logic [IW-1:0] pop_idx;
    logic [IW-1:0] rec_idx;
    logic          out_free;
    logic          keep;
    logic          scan_done;
    logic          chk_wait;

    assign pop_idx   = IDX_TAB[i_rec.entry.key_offset * IW +: IW];
    assign rec_idx   = IDX_TAB[r_rec.entry.key_offset * IW +: IW];
    assign out_free  = ~r_out_v | ~i_out_stall;
    assign keep      = (r_cnt_q <= i_max_matches);
    assign scan_inc  = r_scan + 1'b1;
    assign scan_done = (scan_inc == r_wptr);
    assign chk_wait  = keep & r_pend_v & ~out_free;

    assign o_init_busy = (r_state == B_INIT);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_INIT: begin
                if (r_init == IW'(KEY_OFFSETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_rec_valid) begin
                    n_state = B_UPD;
                end
            end
            B_UPD: begin
                n_state = r_rec.entry.last_entry ? B_SRD : B_IDLE;
            end
            B_SRD: begin
                n_state = B_CRD;
            end
            B_CRD: begin
                n_state = B_CHK;
            end
            B_CHK: begin
                if (!chk_wait) begin
                    n_state = scan_done ? B_FIN : B_SRD;
                end
            end
            B_FIN: begin
                if (out_free) begin
                    n_state = B_CLR_RD;
                end
            end
            B_CLR_RD: begin
                n_state = B_CLR_WR;
            end
            B_CLR_WR: begin
                n_state = scan_done ? B_IDLE : B_CLR_RD;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Datapath controls and next register values.
    always_comb begin
        cnt_re    = 1'b0;
        cnt_ra    = pop_idx;
        cnt_we    = 1'b0;
        cnt_wa    = rec_idx;
        cnt_wd    = '0;
        st_re     = 1'b0;
        st_ra     = r_scan[AW-1:0];
        st_we     = 1'b0;
        st_wa     = r_wptr[AW-1:0];
        st_wd     = '{idx: rec_idx, contig: r_rec.entry.contig,
                      position: r_rec.entry.position, strand: r_rec.entry.strand};
        o_rec_pop = 1'b0;
        n_rec     = r_rec;
        n_ent     = r_ent;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_wptr    = r_wptr;
        n_ovf     = r_ovf;
        n_scan    = r_scan;
        n_init    = r_init;
        n_out     = r_out;
        n_out_v   = i_out_stall ? r_out_v : 1'b0;
        unique case (r_state)
            B_INIT: begin
                // Clearing pass over the count memory after reset.
                cnt_we = 1'b1;
                cnt_wa = r_init;
                cnt_wd = '0;
                n_init = r_init + 1'b1;
            end
            B_IDLE: begin
                // Take the next record and fetch its offset count.
                if (i_rec_valid) begin
                    o_rec_pop = 1'b1;
                    cnt_re    = 1'b1;
                    cnt_ra    = pop_idx;
                    n_rec     = i_rec;
                end
            end
            B_UPD: begin
                // A dropped entry only adds to an offset that a stored one uses.
                if (!(r_rec.drop && r_cnt_q == '0)) begin
                    cnt_we = 1'b1;
                    cnt_wa = rec_idx;
                    cnt_wd = (r_cnt_q == CNT_MAX) ? r_cnt_q : r_cnt_q + 7'd1;
                end
                if (r_rec.drop) begin
                    n_ovf = 1'b1;
                end else begin
                    st_we  = 1'b1;
                    n_wptr = r_wptr + 1'b1;
                end
                n_scan = '0;
            end
            B_SRD: begin
                st_re = 1'b1;
            end
            B_CRD: begin
                cnt_re = 1'b1;
                cnt_ra = r_st_q.idx;
                n_ent  = r_st_q;
            end
            B_CHK: begin
                // The newest kept entry is held back until its successor shows
                // whether it closes the set.
                if (!chk_wait) begin
                    if (keep) begin
                        if (r_pend_v) begin
                            n_out_v = 1'b1;
                            n_out   = '{kept_contig: r_pend.contig,
                                        kept_position: r_pend.position,
                                        kept_strand: r_pend.strand,
                                        set_empty: 1'b0, overflowed: r_ovf,
                                        last_result: 1'b0};
                        end
                        n_pend   = r_ent;
                        n_pend_v = 1'b1;
                    end
                    n_scan = scan_inc;
                end
            end
            B_FIN: begin
                // Final result of the set, or the empty marker.
                if (out_free) begin
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out = '{kept_contig: r_pend.contig,
                                  kept_position: r_pend.position,
                                  kept_strand: r_pend.strand,
                                  set_empty: 1'b0, overflowed: r_ovf,
                                  last_result: 1'b1};
                    end else begin
                        n_out = '{kept_contig: '0, kept_position: '0,
                                  kept_strand: 1'b0, set_empty: 1'b1,
                                  overflowed: r_ovf, last_result: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_scan   = '0;
                end
            end
            B_CLR_RD: begin
                st_re = 1'b1;
            end
            B_CLR_WR: begin
                // Zero the count of every offset the set stored.
                cnt_we = 1'b1;
                cnt_wa = r_st_q.idx;
                cnt_wd = '0;
                n_scan = scan_inc;
                if (scan_done) begin
                    n_wptr = '0;
                    n_ovf  = 1'b0;
                end
            end
            default: begin
                n_scan = r_scan;
            end
        endcase
    end

    // Offset count memory.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_q <= r_cnt_mem[cnt_ra];
        end
    end

    // Entry store.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_st_q <= r_st_mem[st_ra];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rec  <= n_rec;
        r_ent  <= n_ent;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_INIT;
            r_pend_v <= 1'b0;
            r_wptr   <= '0;
            r_ovf    <= 1'b0;
            r_scan   <= '0;
            r_init   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_wptr   <= n_wptr;
            r_ovf    <= n_ovf;
            r_scan   <= n_scan;
            r_init   <= n_init;
            r_out_v  <= n_out_v;
        end
    end

endmodule

### rtl/key_offset_frequency_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_offset_frequency_filter: keeps entries whose key offset is not too common
//
//   Channel  Direction  Handshake          Request
//   in       input      valid / stall      t_kof_in, one candidate entry
//   out      output     valid / stall      t_kof_out, one result
//   cfg      input      valid / ready      max_key_matches, 7 bits
//
// In the back end each entry passes a count read, then the count and store
// writes. After the last entry of a set the back end walks the store to
// emit results (store read, count read, compare per stored entry), issues
// the final result and walks the store again to clear counts (store read,
// count write per stored entry); the queue keeps taking entries meanwhile.
// After reset the count memory is cleared offset by offset, during which
// input is stalled. Results wait in a single output register.
// ----------------------------------------------------------------------------
module key_offset_frequency_filter #(
    parameter int KEY_OFFSETS = 256,
    parameter int MAX_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  kof_pkg::t_kof_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output kof_pkg::t_kof_out o_out_data,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    input  logic [6:0]        i_cfg_data,
    output logic              o_cfg_ready
);
    import kof_pkg::*;

    logic [6:0] r_limit;
    logic       push;
    t_kof_rec   push_rec;
    logic       q_full;
    logic       q_valid;
    t_kof_rec   q_rec;
    logic       q_pop;
    logic       init_busy;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= MAX_MATCHES_RST;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    kof_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_queue_full (q_full),
        .i_init_busy  (init_busy),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    kof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (q_pop)
    );

    kof_back #(
        .KEY_OFFSETS (KEY_OFFSETS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_matches (r_limit),
        .i_rec_valid   (q_valid),
        .i_rec         (q_rec),
        .o_rec_pop     (q_pop),
        .o_init_busy   (init_busy),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule
